@@ hdl/srd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the shadow race detector: stream field
// layout, result status codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package srd_pkg;

    // Stream widths (whole bytes)
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // Input field layout, lowest bit first
    localparam int ADDR_W       = 13;
    localparam int OFF_W        = 3;
    localparam int SLOG_W       = 3;
    localparam int TID_IN_W     = 4;
    localparam int CVAL_W       = 32;
    localparam int GRAN_FIELD_W = ADDR_W - OFF_W;

    localparam int IN_CMD_LSB  = 0;
    localparam int IN_ADDR_LSB = 1;
    localparam int IN_SLOG_LSB = 14;
    localparam int IN_WR_LSB   = 17;
    localparam int IN_TID_LSB  = 18;
    localparam int IN_OTH_LSB  = 22;
    localparam int IN_CVAL_LSB = 26;

    // Command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLOCK  = 1'b1;

    // Largest access size (16 bytes)
    localparam logic [SLOG_W-1:0] MAX_SLOG = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_RACE     = 3'd2;
    localparam logic [2:0] ST_OUTSIDE  = 3'd3;
    localparam logic [2:0] ST_CLOCK    = 3'd4;

    // Controller states, one-hot
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_OWN    = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_FINISH = 7'b0010000,
        S_RACE   = 7'b0100000,
        S_PUT    = 7'b1000000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       clr_step;   // write one entry of the clearing pass
        logic       accept;     // input transfer: latch fields, issue reads
        logic       own;        // latch granule row and own clock
        logic       scan;       // evaluate one slot
        logic       wr_row;     // write back merged row
        logic       wr_zero;    // clear granule after a race
        logic       res_set;    // latch result status
        logic [2:0] res_code;
        logic       out_load;   // move result into output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic in_is_clock;
        logic in_outside;
        logic slot_race;
        logic slot_last;
        logic mod_done;
        logic stored;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/srd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_ctrl
// Sequencer of the race detector: clearing pass after reset, then per access
// accept, own-clock fetch, slot scan, write-back or race clear, result hand-off.
// ----------------------------------------------------------------------------
module srd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  srd_pkg::t_dp_status i_status,
    output srd_pkg::t_ctrl_cmd  o_cmd
);
    import srd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_tready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_is_clock) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ST_CLOCK;
                        n_state        = S_PUT;
                    end else if (i_status.in_outside) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ST_OUTSIDE;
                        n_state        = S_PUT;
                    end else begin
                        n_state = S_OWN;
                    end
                end
            end
            S_OWN: begin
                o_cmd.own = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.slot_race) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_RACE;
                    n_state        = S_RACE;
                end else if (i_status.slot_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // replacement slot needs the clock remainder
                if (i_status.mod_done) begin
                    o_cmd.wr_row   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = i_status.stored ? ST_STORED : ST_REPLACED;
                    n_state        = S_PUT;
                end
            end
            S_RACE: begin
                o_cmd.wr_zero = 1'b1;
                n_state       = S_PUT;
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/srd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_datapath
// Shadow row memory, vector clock memory, slot evaluation, clock-mod-SLOTS
// unit, clearing counter and the result/output registers.
// ----------------------------------------------------------------------------
module srd_datapath #(
    parameter int GRANULES   = 1024,
    parameter int SLOTS      = 4,
    parameter int THREADS    = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [srd_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  srd_pkg::t_ctrl_cmd                 i_cmd,
    output srd_pkg::t_dp_status                o_status,
    input  logic                               i_out_tready,
    output logic                               o_out_tvalid,
    output logic [srd_pkg::OUT_TDATA_W-1:0]    o_out_tdata
);
    import srd_pkg::*;

    localparam int TID_W     = $clog2(THREADS);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GR_W      = (GRANULES > 1) ? $clog2(GRANULES) : 1;
    localparam int GIDX_W    = (GR_W > GRAN_FIELD_W) ? GR_W : GRAN_FIELD_W;
    localparam int GCMP_W    = 21;
    localparam int VC_DEPTH  = THREADS * THREADS;
    localparam int VC_AW     = $clog2(VC_DEPTH);
    localparam int CLR_LEN   = (GRANULES > VC_DEPTH) ? GRANULES : VC_DEPTH;
    localparam int CLR_W     = $clog2(CLR_LEN);
    localparam int MOD_STEPS = (CLOCK_BITS + 7) / 8;
    localparam int MOD_W     = MOD_STEPS * 8;
    localparam int MSTEP_W   = $clog2(MOD_STEPS + 1);

    typedef struct packed {
        logic                  valid;
        logic [CLOCK_BITS-1:0] clk;
        logic [TID_W-1:0]      tid;
        logic                  wr;
        logic [OFF_W-1:0]      off;
        logic [SLOG_W-1:0]     slog;
    } t_shw;

    typedef t_shw [SLOTS-1:0] t_row;

    // Thread id reduced modulo THREADS (4-bit value, at most 7 subtractions)
    function automatic logic [TID_W-1:0] f_tid(input logic [TID_IN_W-1:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int k = 0; k < 8; k++) begin
            if (t >= 9'(THREADS)) begin
                t = t - 9'(THREADS);
            end
        end
        return TID_W'(t);
    endfunction

    // Row-major vector clock address
    function automatic logic [VC_AW-1:0] f_vc_addr(input logic [TID_W-1:0] t,
                                                   input logic [TID_W-1:0] o);
        return VC_AW'(VC_AW'(t) * VC_AW'(THREADS) + VC_AW'(o));
    endfunction

    // Same offset, or byte ranges intersect
    function automatic logic f_overlap(input logic [OFF_W-1:0] ao,
                                       input logic [SLOG_W-1:0] al,
                                       input logic [OFF_W-1:0] bo,
                                       input logic [SLOG_W-1:0] bl);
        logic [4:0] ae;
        logic [4:0] be;
        ae = 5'(ao) + (5'd1 << al);
        be = 5'(bo) + (5'd1 << bl);
        return (ao == bo) || ((5'(ao) < be) && (5'(bo) < ae));
    endfunction

    // Input fields
    logic                    in_cmd;
    logic [ADDR_W-1:0]       in_addr;
    logic [SLOG_W-1:0]       in_slog;
    logic                    in_wr;
    logic [TID_IN_W-1:0]     in_tid;
    logic [TID_IN_W-1:0]     in_oth;
    logic [CVAL_W-1:0]       in_cval;
    logic [GRAN_FIELD_W-1:0] in_gran;
    logic [GIDX_W-1:0]       in_gx;
    logic [GR_W-1:0]         in_gidx;
    logic [TID_W-1:0]        in_tid_m;

    assign in_cmd   = i_tdata[IN_CMD_LSB];
    assign in_addr  = i_tdata[IN_ADDR_LSB +: ADDR_W];
    assign in_slog  = i_tdata[IN_SLOG_LSB +: SLOG_W];
    assign in_wr    = i_tdata[IN_WR_LSB];
    assign in_tid   = i_tdata[IN_TID_LSB +: TID_IN_W];
    assign in_oth   = i_tdata[IN_OTH_LSB +: TID_IN_W];
    assign in_cval  = i_tdata[IN_CVAL_LSB +: CVAL_W];
    assign in_gran  = in_addr[ADDR_W-1:OFF_W];
    assign in_gx    = GIDX_W'(in_gran);
    assign in_gidx  = in_gx[GR_W-1:0];
    assign in_tid_m = f_tid(in_tid);

    // Registers
    logic [TID_W-1:0]      r_thread;
    logic                  r_wr;
    logic [OFF_W-1:0]      r_off;
    logic [SLOG_W-1:0]     r_slog;
    logic [GR_W-1:0]       r_gidx;
    t_row                  r_row;
    t_row                  r_new_row;
    logic [CLOCK_BITS-1:0] r_own_clk;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_stored;
    logic [SLOT_W-1:0]     r_rem;
    logic [MOD_W-1:0]      r_mod_sh;
    logic [MSTEP_W-1:0]    r_mod_cnt;
    logic [CLR_W-1:0]      r_clr;
    t_row                  r_sh_q;
    logic [CLOCK_BITS-1:0] r_vc_q;
    logic [TID_IN_W-1:0]   r_rc_tid;
    logic [CVAL_W-1:0]     r_rc_clk;
    logic                  r_rc_wr;
    logic [OFF_W-1:0]      r_rc_off;
    logic [SLOG_W-1:0]     r_rc_slog;
    logic [2:0]            r_res_status;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Memories
    t_row                  r_sh_mem [GRANULES];
    logic [CLOCK_BITS-1:0] r_vc_mem [VC_DEPTH];

    // Clearing pass bounds
    logic clr_in_gran;
    logic clr_in_vc;
    logic clr_done;
    assign clr_in_gran = (CLR_W+1)'(r_clr) < (CLR_W+1)'(GRANULES);
    assign clr_in_vc   = (CLR_W+1)'(r_clr) < (CLR_W+1)'(VC_DEPTH);
    assign clr_done    = (r_clr == CLR_W'(CLR_LEN - 1));

    // Slot sequencing
    logic              slot_last;
    logic [SLOT_W-1:0] slot_nxt;
    assign slot_last = (r_slot == SLOT_W'(SLOTS - 1));
    assign slot_nxt  = slot_last ? '0 : SLOT_W'(r_slot + 1'b1);

    // Word this access would store
    t_shw nw;
    always_comb begin
        nw.valid = 1'b1;
        nw.clk   = r_own_clk;
        nw.tid   = r_thread;
        nw.wr    = r_wr;
        nw.off   = r_off;
        nw.slog  = r_slog;
    end

    // Slot evaluation against the happens-before clock
    t_shw old;
    logic hb;
    logic ovl;
    logic set_stored;
    logic take;
    logic race;
    always_comb begin
        old        = r_row[r_slot];
        hb         = (r_vc_q >= old.clk);
        ovl        = f_overlap(old.off, old.slog, r_off, r_slog);
        set_stored = 1'b0;
        race       = 1'b0;
        if (!old.valid) begin
            set_stored = 1'b1;
        end else if (ovl && (old.tid != r_thread)) begin
            if (hb) begin
                set_stored = 1'b1;
            end else if (old.wr || r_wr) begin
                race = 1'b1;
            end
        end
        take = set_stored && !r_stored;
    end

    // Clock mod SLOTS, eight bits a cycle from the top
    logic [3:0]        acc;
    logic [SLOT_W-1:0] rem_next;
    always_comb begin
        acc = 4'(r_rem);
        for (int k = 0; k < 8; k++) begin
            acc = {acc[2:0], r_mod_sh[MOD_W-1-k]};
            if (acc >= 4'(SLOTS)) begin
                acc = acc - 4'(SLOTS);
            end
        end
        rem_next = acc[SLOT_W-1:0];
    end

    // Row to write back: replacement when nothing was stored
    t_row fin_row;
    always_comb begin
        fin_row = r_new_row;
        if (!r_stored) begin
            fin_row[r_rem] = nw;
        end
    end

    // Shadow memory write port
    logic            sh_we;
    logic [GR_W-1:0] sh_waddr;
    t_row            sh_wdata;
    always_comb begin
        sh_we    = 1'b0;
        sh_waddr = r_gidx;
        sh_wdata = '0;
        if (i_cmd.clr_step) begin
            sh_we    = clr_in_gran;
            sh_waddr = r_clr[GR_W-1:0];
        end else if (i_cmd.wr_zero) begin
            sh_we = 1'b1;
        end else if (i_cmd.wr_row) begin
            sh_we    = 1'b1;
            sh_wdata = fin_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            r_sh_mem[sh_waddr] <= sh_wdata;
        end
        r_sh_q <= r_sh_mem[in_gidx];
    end

    // Vector clock memory ports
    logic                  vc_we;
    logic [VC_AW-1:0]      vc_waddr;
    logic [CLOCK_BITS-1:0] vc_wdata;
    logic [VC_AW-1:0]      vc_raddr;
    always_comb begin
        vc_we    = 1'b0;
        vc_waddr = f_vc_addr(in_tid_m, f_tid(in_oth));
        vc_wdata = CLOCK_BITS'(in_cval);
        if (i_cmd.clr_step) begin
            vc_we    = clr_in_vc;
            vc_waddr = r_clr[VC_AW-1:0];
            vc_wdata = '0;
        end else if (i_cmd.accept && (in_cmd == CMD_CLOCK)) begin
            vc_we = 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.accept) begin
            vc_raddr = f_vc_addr(in_tid_m, in_tid_m);
        end else if (i_cmd.own) begin
            vc_raddr = f_vc_addr(r_thread, r_sh_q[0].tid);
        end else begin
            vc_raddr = f_vc_addr(r_thread, r_row[slot_nxt].tid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (vc_we) begin
            r_vc_mem[vc_waddr] <= vc_wdata;
        end
        r_vc_q <= r_vc_mem[vc_raddr];
    end

    // Control registers: clearing counter, slot, mod unit, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_slot      <= '0;
            r_stored    <= 1'b0;
            r_mod_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= CLR_W'(r_clr + 1'b1);
            end
            if (i_cmd.own) begin
                r_slot    <= '0;
                r_stored  <= 1'b0;
                r_mod_cnt <= MSTEP_W'(MOD_STEPS);
            end else begin
                if (i_cmd.scan) begin
                    r_slot   <= slot_nxt;
                    r_stored <= r_stored | set_stored;
                end
                if (r_mod_cnt != '0) begin
                    r_mod_cnt <= MSTEP_W'(r_mod_cnt - 1'b1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_thread  <= in_tid_m;
            r_wr      <= in_wr;
            r_off     <= in_addr[OFF_W-1:0];
            r_slog    <= (in_slog > MAX_SLOG) ? MAX_SLOG : in_slog;
            r_gidx    <= in_gidx;
            r_rc_tid  <= '0;
            r_rc_clk  <= '0;
            r_rc_wr   <= 1'b0;
            r_rc_off  <= '0;
            r_rc_slog <= '0;
        end
        if (i_cmd.own) begin
            r_row     <= r_sh_q;
            r_new_row <= r_sh_q;
            r_own_clk <= r_vc_q;
            r_mod_sh  <= MOD_W'(r_vc_q);
            r_rem     <= '0;
        end else if (r_mod_cnt != '0) begin
            r_mod_sh <= r_mod_sh << 8;
            r_rem    <= rem_next;
        end
        if (i_cmd.scan) begin
            if (take) begin
                r_new_row[r_slot] <= nw;
            end
            if (race) begin
                r_rc_tid  <= TID_IN_W'(old.tid);
                r_rc_clk  <= CVAL_W'(old.clk);
                r_rc_wr   <= old.wr;
                r_rc_off  <= old.off;
                r_rc_slog <= old.slog;
            end
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_rc_slog, r_rc_off, r_rc_wr, r_rc_clk, r_rc_tid,
                           r_res_status};
        end
    end

    // Status to controller
    always_comb begin
        o_status.clr_done    = clr_done;
        o_status.in_is_clock = (in_cmd == CMD_CLOCK);
        o_status.in_outside  = (GCMP_W'(in_gran) >= GCMP_W'(GRANULES));
        o_status.slot_race   = race;
        o_status.slot_last   = slot_last;
        o_status.mod_done    = (r_mod_cnt == '0);
        o_status.stored      = r_stored;
        o_status.out_free    = !r_out_valid || i_out_tready;
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = r_out_data;

endmodule

@@ hdl/shadow_race_detector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_race_detector_top
// Shadow-word data race detector: per-granule shadow slots checked against
// per-thread vector clocks; controller and datapath joined by command and
// status structs.
//
//  Channel  Dir  tdata fields (lowest bit first)
//  s_axis   in   cmd, address, size_log2, is_write, thread, other_thread,
//                clock_value
//  m_axis   out  status, race_thread, race_clock, race_was_write,
//                race_offset, race_size_log2
//
// An access goes from transfer to result through one own-clock fetch, one
// slot per cycle over the granule row, a write-back (on a race, a clear of
// the granule) and the result load; the write-back waits for the
// clock-mod-SLOTS unit. Clock commands and accesses outside the shadow go
// from the transfer straight to the result load. After reset a clearing
// pass zeroes both memories with s_axis_tready low.
// A stalled result sits in the output register while the next input is
// accepted; the block then holds in its hand-off state until it drains.
// ----------------------------------------------------------------------------
module shadow_race_detector_top #(
    parameter int GRANULES   = 1024,
    parameter int SLOTS      = 4,
    parameter int THREADS    = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cmd, address, size_log2, is_write, thread, other_thread, clock_value
    input  logic [srd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status, race_thread, race_clock, race_was_write, race_offset,
    // race_size_log2
    output logic [srd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import srd_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // Sequencer
    srd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd)
    );

    // Memories and evaluation
    srd_datapath #(
        .GRANULES   (GRANULES),
        .SLOTS      (SLOTS),
        .THREADS    (THREADS),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tdata      (s_axis_tdata),
        .i_cmd        (ctrl_cmd),
        .o_status     (dp_status),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata)
    );

endmodule
